### rtl/core/tpt_pkg.sv
// Shared types and constants for the triple period timer.
// No dependencies; used by the timer, the output buffer and the top level.
package tpt_pkg;

  localparam int unsigned NumTimers   = 3;
  localparam int unsigned CountW      = 8;
  localparam int unsigned CtrlW       = 7;
  localparam int unsigned ScaleW      = 4;
  localparam int unsigned CfgIndexW   = 3;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = 32;

  localparam int unsigned CtrlEnableBit = 2;
  localparam int unsigned CtrlPreLsb    = 0;
  localparam int unsigned CtrlPostLsb   = 3;

  localparam logic [CountW-1:0] PeriodReset = 8'hFF;

  typedef enum logic [CfgIndexW-1:0] {
    RegCtrlA   = 3'd0,
    RegCtrlB   = 3'd1,
    RegCtrlC   = 3'd2,
    RegPeriodA = 3'd3,
    RegPeriodB = 3'd4,
    RegPeriodC = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PreDiv1   = 2'b00,
    PreDiv4   = 2'b01,
    PreDiv16  = 2'b10,
    PreDiv16b = 2'b11
  } prescale_e;

  typedef struct packed {
    logic                ctrl_we;
    logic                period_we;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [1:0]          pad;
    logic [2:0]          events;
    logic [2:0]          flags;
    logic [CountW-1:0]   count_c;
    logic [CountW-1:0]   count_b;
    logic [CountW-1:0]   count_a;
  } result_t;

  function automatic logic [ScaleW:0] prescale_ratio(input prescale_e sel);
    logic [ScaleW:0] r;
    unique case (sel)
      PreDiv1:  r = 5'd1;
      PreDiv4:  r = 5'd4;
      PreDiv16, PreDiv16b: r = 5'd16;
      default:  r = 5'd16;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/tpt_timer.sv
// One period timer: control, period, prescaler, postscaler and count registers.
// Depends on tpt_pkg.
module tpt_timer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tpt_pkg::cfg_wr_t          wr_i,
  input  logic                      tick_i,
  output logic [tpt_pkg::CountW-1:0] count_o,
  output logic                      event_o
);

  logic [tpt_pkg::CtrlW-1:0]  ctrl_q;
  logic [tpt_pkg::CountW-1:0] period_q;
  logic [tpt_pkg::ScaleW-1:0] pre_q, pre_d;
  logic [tpt_pkg::ScaleW-1:0] post_q, post_d;
  logic [tpt_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [tpt_pkg::ScaleW:0]   pre_inc, post_inc;
  logic [tpt_pkg::ScaleW-1:0] limit;
  logic                       ev;

  assign pre_inc  = {1'b0, pre_q} + 5'd1;
  assign post_inc = {1'b0, post_q} + 5'd1;
  assign limit    = ctrl_q[tpt_pkg::CtrlPostLsb +: tpt_pkg::ScaleW];

  always_comb begin
    pre_d  = pre_q;
    post_d = post_q;
    cnt_d  = cnt_q;
    ev     = 1'b0;
    if (ctrl_q[tpt_pkg::CtrlEnableBit]) begin
      if (pre_inc < tpt_pkg::prescale_ratio(
            tpt_pkg::prescale_e'(ctrl_q[tpt_pkg::CtrlPreLsb +: 2]))) begin
        pre_d = pre_inc[tpt_pkg::ScaleW-1:0];
      end else begin
        pre_d = '0;
        if (cnt_q != period_q) begin
          cnt_d = cnt_q + 8'd1;
        end else begin
          cnt_d = '0;
          if (post_inc > {1'b0, limit}) begin
            post_d = '0;
            ev     = 1'b1;
          end else begin
            post_d = post_inc[tpt_pkg::ScaleW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= '0;
      period_q <= tpt_pkg::PeriodReset;
      pre_q    <= '0;
      post_q   <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i.ctrl_we)   ctrl_q   <= wr_i.data[tpt_pkg::CtrlW-1:0];
      if (wr_i.period_we) period_q <= wr_i.data;
      if (tick_i) begin
        pre_q  <= pre_d;
        post_q <= post_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  assign count_o = cnt_d;
  assign event_o = ev;

endmodule

### rtl/core/tpt_out_buf.sv
// Result register with a skid stage toward the output stream.
// Depends on tpt_pkg.
module tpt_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tpt_pkg::result_t  data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output tpt_pkg::result_t  data_o
);

  logic             out_valid_q, skid_valid_q;
  tpt_pkg::result_t out_q, skid_q;
  logic             pop;

  assign pop     = out_valid_q & pop_ready_i;
  assign ready_o = ~skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (push_i) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push_i) begin
      if (out_valid_q && !pop) skid_q <= data_i;
      else out_q <= data_i;
    end
  end

endmodule

### rtl/core/triple_period_timer_pre_postscale.sv
// Top level of the triple period timer with prescalers and postscalers.
// Depends on tpt_pkg, tpt_timer and tpt_out_buf.
//
//  channel | signals                        | payload (low bit up)
//  s_axis  | tvalid tready tdata[7:0]       | flag_clear[2:0], zero pad
//  m_axis  | tvalid tready tdata[31:0]      | count_a, count_b, count_c, flags, events, pad
//  cfg     | valid ready index[2:0] data    | register index, write data
//
// One tick per cycle while s_axis_tready is high; each taken tick's result is registered.
// The timer state is updated in the cycle of acceptance; the result register
// plus one skid entry hold results while m_axis stalls, and s_axis_tready
// drops only when both are full. Reset clears all counters, controls and flags
// and sets the periods to 255. Config writes are always taken.
module triple_period_timer_pre_postscale (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tpt_pkg::InDataW-1:0]     s_axis_tdata,  // flag_clear[2:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tpt_pkg::OutDataW-1:0]    m_axis_tdata,  // count_a, count_b, count_c, flags, events
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tpt_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [tpt_pkg::CfgDataW-1:0]    cfg_data_i
);

  logic                                     tick;
  logic                                     cfg_we;
  tpt_pkg::cfg_wr_t [tpt_pkg::NumTimers-1:0] wr;
  logic [tpt_pkg::NumTimers-1:0][tpt_pkg::CountW-1:0] count;
  logic [tpt_pkg::NumTimers-1:0]            events;
  logic [tpt_pkg::NumTimers-1:0]            flags_q, flags_d;
  tpt_pkg::result_t                         res;
  tpt_pkg::result_t                         out_data;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign tick        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    for (int t = 0; t < tpt_pkg::NumTimers; t++) begin
      wr[t].ctrl_we   = 1'b0;
      wr[t].period_we = 1'b0;
      wr[t].data      = cfg_data_i;
    end
    if (cfg_we) begin
      unique case (tpt_pkg::cfg_reg_e'(cfg_index_i))
        tpt_pkg::RegCtrlA:   wr[0].ctrl_we   = 1'b1;
        tpt_pkg::RegCtrlB:   wr[1].ctrl_we   = 1'b1;
        tpt_pkg::RegCtrlC:   wr[2].ctrl_we   = 1'b1;
        tpt_pkg::RegPeriodA: wr[0].period_we = 1'b1;
        tpt_pkg::RegPeriodB: wr[1].period_we = 1'b1;
        tpt_pkg::RegPeriodC: wr[2].period_we = 1'b1;
        default: ;
      endcase
    end
  end

  for (genvar t = 0; t < tpt_pkg::NumTimers; t++) begin : g_timer
    tpt_timer u_timer (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (wr[t]),
      .tick_i  (tick),
      .count_o (count[t]),
      .event_o (events[t])
    );
  end

  assign flags_d = (flags_q & ~s_axis_tdata[tpt_pkg::NumTimers-1:0]) | events;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (tick) begin
      flags_q <= flags_d;
    end
  end

  always_comb begin
    res         = '0;
    res.count_a = count[0];
    res.count_b = count[1];
    res.count_c = count[2];
    res.flags   = flags_d;
    res.events  = events;
  end

  tpt_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tick),
    .data_i      (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_data)
  );

  assign m_axis_tdata = out_data;

endmodule

### rtl/core/tpt_checker.sv
// Port-level checks for the triple period timer, bound to the top level.
// Depends on triple_period_timer_pre_postscale.
module tpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        cfg_ready_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[29:27] & ~m_axis_tdata[26:24]) == 3'b000))
    else $error("event without sticky flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind triple_period_timer_pre_postscale tpt_checker u_tpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for triple_period_timer_pre_postscale: a timer predictor
// in a scoreboard class, stream drivers with random bursts and stalls.
// Depends on tpt_pkg and the RTL of the block only.

import tpt_pkg::*;

class timer_scoreboard;
  logic [CtrlW-1:0]  ctrl_reg  [NumTimers];
  logic [CountW-1:0] period_reg[NumTimers];
  logic [ScaleW-1:0] pre_cnt   [NumTimers];
  logic [ScaleW-1:0] post_cnt  [NumTimers];
  logic [CountW-1:0] count_q   [NumTimers];
  logic [2:0]        flags_q;
  result_t           expected_readouts[$];
  int unsigned       errors, ticks, readouts, events_seen, writes;

  function new();
    for (int t = 0; t < NumTimers; t++) begin
      ctrl_reg[t]   = '0;
      period_reg[t] = PeriodReset;
      pre_cnt[t]    = '0;
      post_cnt[t]   = '0;
      count_q[t]    = '0;
    end
    flags_q = '0;
  endfunction

  function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    writes++;
    case (idx)
      RegCtrlA, RegCtrlB, RegCtrlC:       ctrl_reg[idx - RegCtrlA] = data[CtrlW-1:0];
      RegPeriodA, RegPeriodB, RegPeriodC: period_reg[idx - RegPeriodA] = data;
      default: ;
    endcase
  endfunction

  function bit advance_timer(int t);
    logic [ScaleW:0] pre, post;
    int unsigned     ratio;
    if (!ctrl_reg[t][CtrlEnableBit]) return 1'b0;
    case (prescale_e'(ctrl_reg[t][CtrlPreLsb +: 2]))
      PreDiv1: ratio = 1;
      PreDiv4: ratio = 4;
      default: ratio = 16;
    endcase
    pre = pre_cnt[t] + 1'b1;
    if (pre < ratio) begin
      pre_cnt[t] = pre[ScaleW-1:0];
      return 1'b0;
    end
    pre_cnt[t] = '0;
    if (count_q[t] != period_reg[t]) begin
      count_q[t] = count_q[t] + 1'b1;
      return 1'b0;
    end
    count_q[t] = '0;
    post = post_cnt[t] + 1'b1;
    if (post > {1'b0, ctrl_reg[t][CtrlPostLsb +: ScaleW]}) begin
      post_cnt[t] = '0;
      return 1'b1;
    end
    post_cnt[t] = post[ScaleW-1:0];
    return 1'b0;
  endfunction

  function void note_tick(logic [2:0] clear);
    result_t    r;
    logic [2:0] ev;
    ev = '0;
    flags_q = flags_q & ~clear;
    for (int t = 0; t < NumTimers; t++) begin
      if (advance_timer(t)) ev[t] = 1'b1;
    end
    flags_q = flags_q | ev;
    r = '0;
    r.count_a = count_q[0];
    r.count_b = count_q[1];
    r.count_c = count_q[2];
    r.flags   = flags_q;
    r.events  = ev;
    ticks++;
    if (ev != '0) events_seen++;
    expected_readouts.push_back(r);
  endfunction

  function void check_result(logic [OutDataW-1:0] data);
    result_t     got, want;
    logic [7:0]  g_f[5], w_f[5];
    string       f_name[5];
    got = result_t'(data);
    readouts++;
    if (expected_readouts.size() == 0) begin
      errors++;
      $display("%0t: unexpected readout %h, nothing pending", $time, data);
      return;
    end
    want = expected_readouts.pop_front();
    f_name = '{"count_a", "count_b", "count_c", "flags", "events"};
    g_f = '{got.count_a, got.count_b, got.count_c, 8'(got.flags), 8'(got.events)};
    w_f = '{want.count_a, want.count_b, want.count_c, 8'(want.flags), 8'(want.events)};
    for (int i = 0; i < 5; i++) begin
      if (g_f[i] !== w_f[i]) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, f_name[i], w_f[i],
                 g_f[i]);
      end
    end
  endfunction

  function int unsigned pending();
    return expected_readouts.size();
  endfunction
endclass

module tb;
  localparam logic [CfgIndexW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIndexW-1:0] RegSpareHi = 3'd7;
  localparam int unsigned          TargetTicks = 720;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [InDataW-1:0]     s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataW-1:0]    m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIndexW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]    cfg_data_i;

  timer_scoreboard sb;
  int unsigned     burst_left;
  int unsigned     stall_mode, stall_left, stall_cyc;

  triple_period_timer_pre_postscale u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_tick(s_axis_tdata[2:0]);
    end
  end

  // receiver stall pattern: free-running, random, mostly stalled, periodic
  always @(negedge clk_i) begin
    stall_cyc++;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 5) == 0);
      default: m_axis_tready <= ((stall_cyc % 7) < 4);
    endcase
  end

  function automatic logic [CfgDataW-1:0] ctrl_word(bit spare, logic [3:0] post_n, bit en,
                                                    prescale_e pre);
    return {spare, post_n, en, pre};
  endfunction

  task automatic cfg_write(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_tick(logic [2:0] clear);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-3){1'b0}}, clear};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // drop valid and drain all pending readouts
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic send_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk_i);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 100)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      send_tick(3'($urandom & $urandom));
    end
  endtask

  task automatic random_config();
    cfg_reg_e    ctrl_regs[3];
    cfg_reg_e    period_regs[3];
    logic [3:0]  post_n;
    logic [7:0]  per;
    int unsigned pick;
    ctrl_regs   = '{RegCtrlA, RegCtrlB, RegCtrlC};
    period_regs = '{RegPeriodA, RegPeriodB, RegPeriodC};
    for (int t = 0; t < NumTimers; t++) begin
      if ($urandom_range(0, 9) < 6) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          cfg_write(ctrl_regs[t], '0);
        end else if (pick < 3) begin
          cfg_write(ctrl_regs[t], {1'($urandom_range(0, 1)), 7'h7F});
        end else begin
          pick = $urandom_range(0, 9);
          post_n = (pick < 3) ? 4'd0 : (pick < 5) ? 4'd15 : (pick < 8) ? 4'($urandom_range(1, 3))
                                                                      : 4'($urandom);
          cfg_write(ctrl_regs[t], ctrl_word(1'($urandom_range(0, 1)), post_n,
                                            $urandom_range(0, 6) != 0,
                                            prescale_e'(2'($urandom))));
        end
      end
      if ($urandom_range(0, 9) < 6) begin
        pick = $urandom_range(0, 9);
        per = (pick < 2) ? 8'd0 : (pick < 3) ? 8'd255 : (pick < 8) ? 8'($urandom_range(1, 4))
                                                                  : 8'($urandom);
        cfg_write(period_regs[t], per);
      end
    end
    if ($urandom_range(0, 9) == 0)
      cfg_write($urandom_range(0, 1) ? RegSpareHi : RegSpareLo, 8'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned phases;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    burst_left    = 0;
    phases        = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset config: all timers disabled
    send_tick(3'b000);
    send_tick(3'b111);
    settle();

    // event on every tick for A, B counts postscale up, C sits mid-prescale
    cfg_write(RegCtrlA, ctrl_word(1'b0, 4'd0, 1'b1, PreDiv1));
    cfg_write(RegPeriodA, 8'd0);
    cfg_write(RegCtrlB, ctrl_word(1'b1, 4'd15, 1'b1, PreDiv4));
    cfg_write(RegPeriodB, 8'd0);
    cfg_write(RegCtrlC, ctrl_word(1'b0, 4'd2, 1'b1, PreDiv16));
    cfg_write(RegPeriodC, 8'd255);
    cfg_write(RegSpareLo, 8'hFF);
    cfg_write(RegSpareHi, 8'hFF);
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < 12; i++) send_tick(3'(i));
    settle();

    // freeze A, lower B postscale mid-count, shorten C prescale mid-count
    cfg_write(RegCtrlA, '0);
    cfg_write(RegCtrlB, ctrl_word(1'b0, 4'd1, 1'b1, PreDiv1));
    cfg_write(RegCtrlC, ctrl_word(1'b0, 4'd2, 1'b1, PreDiv4));
    cfg_write(RegPeriodC, 8'd0);
    cfg_valid_i <= 1'b0;
    for (int i = 7; i >= 0; i--) send_tick(3'(i));
    settle();

    while (sb.ticks < TargetTicks) begin
      random_config();
      phases++;
      send_random(($urandom_range(0, 6) == 0) ? $urandom_range(260, 320)
                                              : $urandom_range(20, 60));
      settle();
    end
    repeat (8) @(posedge clk_i);

    $display("Covered %0d ticks in %0d random phases, %0d config writes.", sb.ticks, phases,
             sb.writes);
    $display("Checked %0d readouts, %0d with timer events.", sb.readouts, sb.events_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
